>>> rtl/core/face_fan_triangle_assembler_assert.svh
// Assertion macros for the face fan triangle assembler
`ifndef FACE_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH
`define FACE_FAN_TRIANGLE_ASSEMBLER_ASSERT_SVH

`ifndef SYNTHESIS

`define FFTA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ffta: property failed");

`define FFTA_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ffta: forbidden condition seen");

`else

`define FFTA_ASSERT(lbl, clk, rst, prop)

`define FFTA_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

>>> rtl/core/ffta_pkg.sv
// Shared types, constants and index resolution for the face fan triangle assembler
`default_nettype none

package ffta_pkg;

   localparam int POSITION_DEPTH = 4096;
   localparam int TEXCOORD_DEPTH = 4096;
   localparam int NORMAL_DEPTH   = 4096;

   localparam int POS_ADDR_W = $clog2(POSITION_DEPTH);
   localparam int TEX_ADDR_W = $clog2(TEXCOORD_DEPTH);
   localparam int NRM_ADDR_W = $clog2(NORMAL_DEPTH);
   localparam int POS_FILL_W = $clog2(POSITION_DEPTH + 1);
   localparam int TEX_FILL_W = $clog2(TEXCOORD_DEPTH + 1);
   localparam int NRM_FILL_W = $clog2(NORMAL_DEPTH + 1);

   localparam int WORD_W      = 32;
   localparam int IDX_W       = 17;
   localparam int OPCODE_W    = 2;
   localparam int REQ_TDATA_W = 152;
   localparam int RSP_TDATA_W = 256;
   localparam int RSP_TUSER_W = 3;

   // rsp_tuser bit positions
   localparam int RSP_TEX_BIT = 0;
   localparam int RSP_NRM_BIT = 1;
   localparam int RSP_ERR_BIT = 2;

   localparam logic [OPCODE_W-1:0] OP_ADD_POS = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_TEX = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_ADD_NRM = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CORNER  = 2'd3;

   // triangle slots: fan origin, previous corner, current corner
   localparam logic [1:0] SLOT_FIRST = 2'd0;
   localparam logic [1:0] SLOT_PREV  = 2'd1;
   localparam logic [1:0] SLOT_CUR   = 2'd2;

   typedef struct packed {
      logic signed [IDX_W-1:0] pi;
      logic signed [IDX_W-1:0] ti;
      logic signed [IDX_W-1:0] ni;
      logic                    ht;
      logic                    hn;
   } corner_type;

   typedef struct packed {
      logic             ok;
      logic [IDX_W-1:0] addr;
   } res_type;

   typedef struct packed {
      logic       corner_acc;
      logic       load_first;
      logic       append;
      logic       resolve;
      logic [1:0] slot;
      logic       read;
      logic [1:0] rd_slot;
      logic       load_err;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic last;
   } sts_type;

   // one-based index, negative counts back from fill; zero or out of range is bad
   function automatic res_type resolve_idx(input logic signed [IDX_W-1:0] idx,
                                           input logic [IDX_W-1:0] fill);
      logic signed [IDX_W:0] idx_x;
      logic signed [IDX_W:0] fill_x;
      logic signed [IDX_W:0] r;
      res_type               res;
      idx_x  = (IDX_W+1)'(idx);
      fill_x = $signed({1'b0, fill});
      r      = idx[IDX_W-1] ? (fill_x + idx_x + (IDX_W+1)'(1)) : idx_x;
      res.ok   = (r > (IDX_W+1)'(0)) && (r <= fill_x);
      res.addr = IDX_W'(r - (IDX_W+1)'(1));
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/face_fan_triangle_assembler.sv
// Top level of the face fan triangle assembler: stream ports, controller and datapath.
// Appends and the first two corners of a face are taken without leaving idle.
// A corner closing a triangle resolves origin, previous and current corners in turn
// through one shared resolver, then gives 3 corner transactions from the store read
// ports, one per cycle unless stalled, or one error transaction if an index is bad.
// Synchronous active-high reset empties all stores and clears face tracking.
`default_nettype none

`include "face_fan_triangle_assembler_assert.svh"

module face_fan_triangle_assembler (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // word_a, word_b, word_c, position_index, texcoord_index, normal_index,
   // corner_has_texture, corner_has_normal, zero pad
   input  wire logic [ffta_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // opcode
   input  wire logic [ffta_pkg::OPCODE_W-1:0]         req_tuser,
   input  wire logic                                  req_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v, norm_i, norm_j, norm_k
   output logic [ffta_pkg::RSP_TDATA_W-1:0]           rsp_tdata,
   // out_has_texture, out_has_normal, index_error
   output logic [ffta_pkg::RSP_TUSER_W-1:0]           rsp_tuser,
   output logic                                       rsp_tlast
);

   ffta_pkg::cmd_type    cmd;
   ffta_pkg::sts_type    sts;
   ffta_pkg::corner_type req_corner;

   assign req_corner.pi = $signed(req_tdata[112:96]);
   assign req_corner.ti = $signed(req_tdata[129:113]);
   assign req_corner.ni = $signed(req_tdata[146:130]);
   assign req_corner.ht = req_tdata[147];
   assign req_corner.hn = req_tdata[148];

   ffta_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_opcode   (req_tuser),
      .req_face_end (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .cmd          (cmd),
      .sts          (sts)
   );

   ffta_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_opcode (req_tuser),
      .word_a     (req_tdata[31:0]),
      .word_b     (req_tdata[63:32]),
      .word_c     (req_tdata[95:64]),
      .req_corner (req_corner),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `FFTA_ASSERT_NEVER(a_no_overlap, clock, reset, req_tready && rsp_tvalid)
   `FFTA_ASSERT(a_err_alone, clock, reset, rsp_tvalid && rsp_tuser[ffta_pkg::RSP_ERR_BIT] |-> rsp_tlast && (rsp_tdata == '0))
   `FFTA_ASSERT(a_idle_after_last, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)

endmodule

`default_nettype wire

>>> rtl/core/ffta_ctrl.sv
// Controller: face corner tracking and triangle sequencing
`default_nettype none

module ffta_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ffta_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic                              req_face_end,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output ffta_pkg::cmd_type                      cmd,
   input  wire ffta_pkg::sts_type                 sts
);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_RESOLVE = 2'd1;
   localparam logic [1:0] ST_SEND    = 2'd2;

   localparam logic [1:0] SEEN_NONE = 2'd0;
   localparam logic [1:0] SEEN_ONE  = 2'd1;
   localparam logic [1:0] SEEN_TWO  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] seen_ff, seen_in;
   logic [1:0] slot_ff, slot_in;
   logic       req_acc;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign req_acc    = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      slot_in  = slot_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_opcode == ffta_pkg::OP_CORNER) begin
                  cmd.corner_acc = 1'b1;
                  cmd.load_first = (seen_ff == SEEN_NONE);
                  if (seen_ff == SEEN_TWO) begin
                     state_in = ST_RESOLVE;
                     slot_in  = ffta_pkg::SLOT_FIRST;
                  end
                  if (req_face_end) begin
                     seen_in = SEEN_NONE;
                  end else begin
                     seen_in = (seen_ff == SEEN_NONE) ? SEEN_ONE : SEEN_TWO;
                  end
               end else begin
                  cmd.append = 1'b1;
               end
            end
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            cmd.slot    = slot_ff;
            if (slot_ff == ffta_pkg::SLOT_CUR) begin
               state_in = ST_SEND;
               slot_in  = ffta_pkg::SLOT_FIRST;
               if (sts.bad) begin
                  cmd.load_err = 1'b1;
               end else begin
                  cmd.read    = 1'b1;
                  cmd.rd_slot = ffta_pkg::SLOT_FIRST;
               end
            end else begin
               slot_in = slot_ff + 2'd1;
            end
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.read    = 1'b1;
                  cmd.rd_slot = slot_ff + 2'd1;
                  slot_in     = slot_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= SEEN_NONE;
         slot_ff  <= ffta_pkg::SLOT_FIRST;
      end else begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ffta_dp.sv
// Datapath: attribute stores, corner registers, index resolver and result register
`default_nettype none

module ffta_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ffta_pkg::cmd_type                     cmd,
   output ffta_pkg::sts_type                          sts,
   input  wire logic [ffta_pkg::OPCODE_W-1:0]         req_opcode,
   input  wire logic [ffta_pkg::WORD_W-1:0]           word_a,
   input  wire logic [ffta_pkg::WORD_W-1:0]           word_b,
   input  wire logic [ffta_pkg::WORD_W-1:0]           word_c,
   input  wire ffta_pkg::corner_type                  req_corner,
   output logic [ffta_pkg::RSP_TDATA_W-1:0]           rsp_tdata,
   output logic [ffta_pkg::RSP_TUSER_W-1:0]           rsp_tuser,
   output logic                                       rsp_tlast
);

   localparam int W = ffta_pkg::WORD_W;

   logic [3*W-1:0] pos_mem_ff [ffta_pkg::POSITION_DEPTH];
   logic [2*W-1:0] tex_mem_ff [ffta_pkg::TEXCOORD_DEPTH];
   logic [3*W-1:0] nrm_mem_ff [ffta_pkg::NORMAL_DEPTH];

   logic [ffta_pkg::POS_FILL_W-1:0] pos_fill_ff;
   logic [ffta_pkg::TEX_FILL_W-1:0] tex_fill_ff;
   logic [ffta_pkg::NRM_FILL_W-1:0] nrm_fill_ff;
   logic                            pos_wr, tex_wr, nrm_wr;

   ffta_pkg::corner_type first_ff, prev_ff, cur_ff;
   ffta_pkg::corner_type slot_corner [3];
   ffta_pkg::corner_type sel;
   ffta_pkg::corner_type rd_corner;
   ffta_pkg::res_type    p_res, t_res, n_res;
   logic                 slot_bad;

   logic [ffta_pkg::POS_ADDR_W-1:0] pos_addr_ff [3];
   logic [ffta_pkg::TEX_ADDR_W-1:0] tex_addr_ff [3];
   logic [ffta_pkg::NRM_ADDR_W-1:0] nrm_addr_ff [3];
   logic                            bad_ff;

   logic [3*W-1:0] pos_q_ff;
   logic [2*W-1:0] tex_q_ff;
   logic [3*W-1:0] nrm_q_ff;
   logic           ht_ff, hn_ff, err_ff, last_ff;

   // appends beyond capacity are dropped
   assign pos_wr = cmd.append && (req_opcode == ffta_pkg::OP_ADD_POS) &&
                   (pos_fill_ff < ffta_pkg::POS_FILL_W'(ffta_pkg::POSITION_DEPTH));
   assign tex_wr = cmd.append && (req_opcode == ffta_pkg::OP_ADD_TEX) &&
                   (tex_fill_ff < ffta_pkg::TEX_FILL_W'(ffta_pkg::TEXCOORD_DEPTH));
   assign nrm_wr = cmd.append && (req_opcode == ffta_pkg::OP_ADD_NRM) &&
                   (nrm_fill_ff < ffta_pkg::NRM_FILL_W'(ffta_pkg::NORMAL_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_fill_ff <= '0;
         tex_fill_ff <= '0;
         nrm_fill_ff <= '0;
      end else begin
         if (pos_wr) pos_fill_ff <= pos_fill_ff + 1'b1;
         if (tex_wr) tex_fill_ff <= tex_fill_ff + 1'b1;
         if (nrm_wr) nrm_fill_ff <= nrm_fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_wr) pos_mem_ff[pos_fill_ff[ffta_pkg::POS_ADDR_W-1:0]] <= {word_c, word_b, word_a};
      if (tex_wr) tex_mem_ff[tex_fill_ff[ffta_pkg::TEX_ADDR_W-1:0]] <= {word_b, word_a};
      if (nrm_wr) nrm_mem_ff[nrm_fill_ff[ffta_pkg::NRM_ADDR_W-1:0]] <= {word_c, word_b, word_a};
   end

   // corner history: previous always trails current by one corner
   always_ff @(posedge clock) begin
      if (cmd.corner_acc) begin
         cur_ff  <= req_corner;
         prev_ff <= cur_ff;
         if (cmd.load_first) first_ff <= req_corner;
      end
   end

   assign slot_corner[ffta_pkg::SLOT_FIRST] = first_ff;
   assign slot_corner[ffta_pkg::SLOT_PREV]  = prev_ff;
   assign slot_corner[ffta_pkg::SLOT_CUR]   = cur_ff;

   always_comb begin
      case (cmd.slot)
         ffta_pkg::SLOT_FIRST: sel = first_ff;
         ffta_pkg::SLOT_PREV:  sel = prev_ff;
         default:              sel = cur_ff;
      endcase
   end

   assign p_res = ffta_pkg::resolve_idx(sel.pi, ffta_pkg::IDX_W'(pos_fill_ff));
   assign t_res = ffta_pkg::resolve_idx(sel.ti, ffta_pkg::IDX_W'(tex_fill_ff));
   assign n_res = ffta_pkg::resolve_idx(sel.ni, ffta_pkg::IDX_W'(nrm_fill_ff));

   assign slot_bad = !p_res.ok || (sel.ht && !t_res.ok) || (sel.hn && !n_res.ok);

   always_ff @(posedge clock) begin
      if (cmd.resolve) begin
         pos_addr_ff[cmd.slot] <= p_res.addr[ffta_pkg::POS_ADDR_W-1:0];
         tex_addr_ff[cmd.slot] <= t_res.addr[ffta_pkg::TEX_ADDR_W-1:0];
         nrm_addr_ff[cmd.slot] <= n_res.addr[ffta_pkg::NRM_ADDR_W-1:0];
         bad_ff <= ((cmd.slot != ffta_pkg::SLOT_FIRST) && bad_ff) || slot_bad;
      end
   end

   assign sts.bad  = ((cmd.slot != ffta_pkg::SLOT_FIRST) && bad_ff) || slot_bad;
   assign sts.last = last_ff;

   assign rd_corner = slot_corner[cmd.rd_slot];

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         pos_q_ff <= pos_mem_ff[pos_addr_ff[cmd.rd_slot]];
         tex_q_ff <= tex_mem_ff[tex_addr_ff[cmd.rd_slot]];
         nrm_q_ff <= nrm_mem_ff[nrm_addr_ff[cmd.rd_slot]];
         ht_ff    <= rd_corner.ht;
         hn_ff    <= rd_corner.hn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= 1'b0;
         last_ff <= 1'b0;
      end else if (cmd.load_err) begin
         err_ff  <= 1'b1;
         last_ff <= 1'b1;
      end else if (cmd.read) begin
         err_ff  <= 1'b0;
         last_ff <= (cmd.rd_slot == ffta_pkg::SLOT_CUR);
      end
   end

   // absent attributes and the error transaction read as zero
   assign rsp_tdata = err_ff ? '0 :
                      {(hn_ff ? nrm_q_ff : {(3*W){1'b0}}),
                       (ht_ff ? tex_q_ff : {(2*W){1'b0}}),
                       pos_q_ff};
   assign rsp_tuser[ffta_pkg::RSP_TEX_BIT] = ht_ff && !err_ff;
   assign rsp_tuser[ffta_pkg::RSP_NRM_BIT] = hn_ff && !err_ff;
   assign rsp_tuser[ffta_pkg::RSP_ERR_BIT] = err_ff;
   assign rsp_tlast = last_ff;

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the face fan triangle assembler stream block
`timescale 1ns / 100ps
`default_nettype none

module tb;

   localparam int W            = ffta_pkg::WORD_W;
   localparam int IW           = ffta_pkg::IDX_W;
   localparam int RANDOM_ITEMS = 180;
   localparam int CYCLE_LIMIT  = 60000;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [ffta_pkg::OPCODE_W-1:0] op;
      logic [W-1:0]                  a;
      logic [W-1:0]                  b;
      logic [W-1:0]                  c;
      logic signed [IW-1:0]          pi;
      logic signed [IW-1:0]          ti;
      logic signed [IW-1:0]          ni;
      logic                          ht;
      logic                          hn;
      logic                          fe;
   } face_item_type;

   typedef struct packed {
      logic signed [IW-1:0] pi;
      logic signed [IW-1:0] ti;
      logic signed [IW-1:0] ni;
      logic                 ht;
      logic                 hn;
   } corner_ref_type;

   typedef struct packed {
      logic [ffta_pkg::RSP_TDATA_W-1:0] words;
      logic                             tex;
      logic                             nrm;
      logic                             last;
      logic                             err;
   } corner_out_type;

   typedef struct packed {
      face_item_type item;
      logic          typed_err;
   } plan_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [ffta_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [ffta_pkg::OPCODE_W-1:0]    req_tuser = '0;
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [ffta_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [ffta_pkg::RSP_TUSER_W-1:0] rsp_tuser;
   logic                             rsp_tlast;

   face_fan_triangle_assembler dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // predictor state
   logic [3*W-1:0]  pos_mem [ffta_pkg::POSITION_DEPTH];
   logic [2*W-1:0]  tex_mem [ffta_pkg::TEXCOORD_DEPTH];
   logic [3*W-1:0]  nrm_mem [ffta_pkg::NORMAL_DEPTH];
   int              pos_fill = 0;
   int              tex_fill = 0;
   int              nrm_fill = 0;
   corner_ref_type  origin = '0;
   corner_ref_type  prior = '0;
   int              corners_seen = 0;

   corner_out_type triangle_out [$];
   corner_out_type corners_due [$];
   plan_row_type   directed [$];

   int  fail_count = 0;
   int  sent = 0;
   int  cycles = 0;
   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_req = 0;
   bit  holding = 0;

   string word_tag [8] = '{"pos_x", "pos_y", "pos_z", "tex_u", "tex_v",
                           "norm_i", "norm_j", "norm_k"};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // receiver back-pressure
   initial begin
      forever begin
         @(posedge clock);
         rsp_tready <= !holding && ($urandom_range(99) >= stall_pct);
      end
   end

   // long receiver hold-off, so the block backs up into its input
   initial begin
      wait (hold_req);
      @(posedge clock);
      holding = 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding = 0;
   end

   task automatic report(input string what, input logic [W-1:0] got,
                         input logic [W-1:0] want);
      $display("MISMATCH %s: got %h expected %h (t=%0t)", what, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int locate(input logic signed [IW-1:0] idx, input int fill);
      int r;
      r = idx;
      if (r < 0)
         r = fill + 1 + r;
      if (r <= 0 || r > fill)
         return -1;
      return r - 1;
   endfunction

   function automatic bit fetch_corner(input corner_ref_type cr, output corner_out_type o);
      int pa;
      int ta;
      int na;
      o  = '0;
      ta = 0;
      na = 0;
      pa = locate(cr.pi, pos_fill);
      if (pa < 0)
         return 0;
      if (cr.ht) begin
         ta = locate(cr.ti, tex_fill);
         if (ta < 0)
            return 0;
      end
      if (cr.hn) begin
         na = locate(cr.ni, nrm_fill);
         if (na < 0)
            return 0;
      end
      o.words[95:0] = pos_mem[pa];
      if (cr.ht)
         o.words[159:96] = tex_mem[ta];
      if (cr.hn)
         o.words[255:160] = nrm_mem[na];
      o.tex = cr.ht;
      o.nrm = cr.hn;
      return 1;
   endfunction

   // store appends and fan triangulation; results land in triangle_out
   function automatic void fan_triangulate(input face_item_type it);
      corner_ref_type cur;
      corner_out_type r0;
      corner_out_type r1;
      corner_out_type r2;
      bit             ok;
      triangle_out.delete();
      case (it.op)
         ffta_pkg::OP_ADD_POS: begin
            if (pos_fill < ffta_pkg::POSITION_DEPTH) begin
               pos_mem[pos_fill] = {it.c, it.b, it.a};
               pos_fill++;
            end
         end
         ffta_pkg::OP_ADD_TEX: begin
            if (tex_fill < ffta_pkg::TEXCOORD_DEPTH) begin
               tex_mem[tex_fill] = {it.b, it.a};
               tex_fill++;
            end
         end
         ffta_pkg::OP_ADD_NRM: begin
            if (nrm_fill < ffta_pkg::NORMAL_DEPTH) begin
               nrm_mem[nrm_fill] = {it.c, it.b, it.a};
               nrm_fill++;
            end
         end
         default: begin
            cur = '{pi: it.pi, ti: it.ti, ni: it.ni, ht: it.ht, hn: it.hn};
            if (corners_seen == 0) begin
               origin       = cur;
               corners_seen = 1;
            end else if (corners_seen == 1) begin
               corners_seen = 2;
            end else begin
               ok = fetch_corner(origin, r0);
               if (ok)
                  ok = fetch_corner(prior, r1);
               if (ok)
                  ok = fetch_corner(cur, r2);
               if (ok) begin
                  r2.last      = 1'b1;
                  triangle_out = {triangle_out, r0, r1, r2};
               end else begin
                  r0           = '0;
                  r0.last      = 1'b1;
                  r0.err       = 1'b1;
                  triangle_out = {triangle_out, r0};
               end
            end
            prior = cur;
            if (it.fe)
               corners_seen = 0;
         end
      endcase
   endfunction

   task automatic send(input face_item_type it, input bit typed_err);
      corner_out_type e;
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tlast  <= it.fe;
      req_tdata  <= {3'b000, it.hn, it.ht, it.ni, it.ti, it.pi, it.c, it.b, it.a};
      do @(posedge clock); while (!req_tready);
      fan_triangulate(it);
      if (typed_err) begin
         e           = '0;
         e.last      = 1'b1;
         e.err       = 1'b1;
         corners_due = {corners_due, e};
      end else begin
         foreach (triangle_out[k])
            corners_due = {corners_due, triangle_out[k]};
      end
      sent++;
   endtask

   function automatic void add_row(input logic [ffta_pkg::OPCODE_W-1:0] op,
                                   input logic [W-1:0] a, input logic [W-1:0] b,
                                   input logic [W-1:0] c,
                                   input int pi, input int ti, input int ni,
                                   input bit ht, input bit hn, input bit fe, input bit typed);
      plan_row_type row;
      row.item = '{op: op, a: a, b: b, c: c, pi: IW'(pi), ti: IW'(ti), ni: IW'(ni),
                   ht: ht, hn: hn, fe: fe};
      row.typed_err = typed;
      directed      = {directed, row};
   endfunction

   function automatic logic signed [IW-1:0] pick_index(input int fill, input bit wild);
      if (wild || fill == 0)
         return IW'($urandom());
      if ($urandom_range(99) < 4) begin
         case ($urandom_range(2))
            0: return '0;
            1: return IW'(fill + 1 + int'($urandom_range(50)));
            default: return IW'(-(fill + 1));
         endcase
      end
      if ($urandom_range(1))
         return IW'($urandom_range(fill, 1));
      return IW'(-int'($urandom_range(fill, 1)));
   endfunction

   function automatic face_item_type random_append();
      face_item_type it;
      it    = face_item_type'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
      it.op = ffta_pkg::OPCODE_W'($urandom_range(2));
      return it;
   endfunction

   task automatic random_face();
      int            n;
      bit            noise;
      face_item_type it;
      n     = ($urandom_range(99) < 15) ? int'($urandom_range(2, 1))
                                        : int'($urandom_range(6, 3));
      noise = ($urandom_range(99) < 10);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(99) < 20)
            send(random_append(), 1'b0);
         it    = face_item_type'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
         it.op = ffta_pkg::OP_CORNER;
         it.ht = 1'($urandom_range(1));
         it.hn = 1'($urandom_range(1));
         it.pi = pick_index(pos_fill, noise);
         it.ti = pick_index(tex_fill, noise);
         it.ni = pick_index(nrm_fill, noise);
         it.fe = noise ? 1'($urandom_range(1)) : (k == n - 1);
         send(it, 1'b0);
      end
   endtask

   always @(posedge clock) begin : check_rsp
      corner_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (corners_due.size() == 0) begin
            report("rsp transaction with nothing expected", rsp_tdata[31:0], '0);
         end else begin
            want = corners_due.pop_front();
            for (int k = 0; k < 8; k++)
               if (rsp_tdata[32*k +: 32] !== want.words[32*k +: 32])
                  report(word_tag[k], rsp_tdata[32*k +: 32], want.words[32*k +: 32]);
            if (rsp_tuser[ffta_pkg::RSP_TEX_BIT] !== want.tex)
               report("out_has_texture", W'(rsp_tuser[ffta_pkg::RSP_TEX_BIT]), W'(want.tex));
            if (rsp_tuser[ffta_pkg::RSP_NRM_BIT] !== want.nrm)
               report("out_has_normal", W'(rsp_tuser[ffta_pkg::RSP_NRM_BIT]), W'(want.nrm));
            if (rsp_tlast !== want.last)
               report("last_corner", W'(rsp_tlast), W'(want.last));
            if (rsp_tuser[ffta_pkg::RSP_ERR_BIT] !== want.err)
               report("index_error", W'(rsp_tuser[ffta_pkg::RSP_ERR_BIT]), W'(want.err));
         end
      end
   end

   initial begin : stimulus
      int base;

      // empty stores: triangle must fail
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, -1, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 0, 0, 0, 1, 1);
      add_row(ffta_pkg::OP_ADD_POS, '1, '1, '1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_POS, '0, '0, '0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_POS, 32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c,
              0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_TEX, '1, '0, 32'hdeadbeef, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_TEX, '0, '1, '0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_NRM, '1, '0, '1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_ADD_NRM, '0, '1, '0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, -1, 1, 1, 1, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '1, '1, '1, -1, 1, -2, 1, 1, 0, 0);
      // disabled indices are never checked
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 2, 0, -65536, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, -3, 2, 2, 1, 1, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 0, 0, 0, 0, 0, 1, 1);
      // two-corner face
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 2, 0, 0, 0, 0, 1, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, -65536, 65535, 0, 1, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 0, 0, 0, 1, 1);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 1, 0, 3, 0, 1, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 2, 0, 0, 0, 0, 0, 0);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 3, 0, 0, 0, 0, 1, 1);
      add_row(ffta_pkg::OP_CORNER, '0, '0, '0, 65535, -65536, 65535, 0, 0, 1, 0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k])
         send(directed[k].item, directed[k].typed_err);

      base = sent;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  hold_req = 1; end
            1: begin idle_pct = 52; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 52; end
            default: begin idle_pct = 29; stall_pct = 29; end
         endcase
         while (sent < base + (ph + 1) * RANDOM_ITEMS / 4)
            random_face();
      end

      req_tvalid <= 1'b0;
      while (corners_due.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);

      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
